// ===== design/operating_point_select_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// operating point select sequencer assertion macros
// concurrent checks sampled on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef OPERATING_POINT_SELECT_SEQUENCER_MACROS_SVH
`define OPERATING_POINT_SELECT_SEQUENCER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define OPSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("opss check failed");
// next-cycle implication
`define OPSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("opss check failed");
`else
`define OPSS_ASSERT_IMP(lbl, ante, cons)
`define OPSS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/opss_pkg.sv =====
// ----------------------------------------------------------------------------
// opss_pkg
// shared types, constants and the operating-point rom of the sequencer
// ----------------------------------------------------------------------------
package opss_pkg;

  // field widths
  localparam int KHZ_W  = 20;
  localparam int REL_W  = 2;
  localparam int ACT_W  = 3;
  localparam int VAL_W  = 9;
  localparam int MUL_W  = 5;
  localparam int CPU_W  = 5;
  localparam int AHB_W  = 3;
  localparam int PROD_W = 21;
  localparam int ROM_IDX_W = 5;
  localparam int SLOT_W = 2;

  // configuration
  localparam int NUM_POINTS_DEFAULT = 15;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int REG_POLICY_MIN = 0;
  localparam int REG_POLICY_MAX = 1;
  localparam logic [KHZ_W-1:0] POLICY_MIN_RESET = 20'd100001;
  localparam logic [KHZ_W-1:0] POLICY_MAX_RESET = 20'd350002;

  // kept register reset values
  localparam logic [VAL_W-1:0] PLL_RESET = 9'h01C;
  localparam logic [CPU_W-1:0] CPU_RESET = 5'd2;
  localparam logic [AHB_W-1:0] AHB_RESET = 3'd2;
  localparam int BYPASS_BIT = 8;

  localparam logic [PROD_W-1:0] BASE_KHZ = 21'd66000;

  // relation codes
  localparam logic [REL_W-1:0] REL_ABOVE = 2'd0;
  localparam logic [REL_W-1:0] REL_BELOW = 2'd1;

  // final emit slot carries the restart beat
  localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_AHB     = 3'd0,
    ACT_PLL     = 3'd1,
    ACT_CPU     = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_NONE    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ADJUST,
    ST_DIVIDE,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [KHZ_W-1:0] khz;
    logic [MUL_W-1:0] mul;
    logic             bypass;
    logic [CPU_W-1:0] cpu;
    logic [AHB_W-1:0] ahb;
  } op_point_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              search_step;
    logic              adjust;
    logic              div_start;
    logic              emit;
    logic              none;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_done;
    logic div_busy;
    logic same;
    logic slot_en;
    logic out_free;
  } stat_t;

  // operating-point rom, entries past the last defined one repeat it
  function automatic op_point_t rom_point(logic [ROM_IDX_W-1:0] idx);
    op_point_t p;
    unique case (idx)
      5'd0:    p = '{20'd50001,  5'h04, 1'b0, 5'd2, 3'd1};
      5'd1:    p = '{20'd75001,  5'h06, 1'b0, 5'd2, 3'd1};
      5'd2:    p = '{20'd100001, 5'h08, 1'b0, 5'd2, 3'd1};
      5'd3:    p = '{20'd125002, 5'h0A, 1'b0, 5'd2, 3'd2};
      5'd4:    p = '{20'd150002, 5'h0C, 1'b0, 5'd2, 3'd2};
      5'd5:    p = '{20'd175002, 5'h0E, 1'b0, 5'd2, 3'd2};
      5'd6:    p = '{20'd200002, 5'h10, 1'b0, 5'd2, 3'd2};
      5'd7:    p = '{20'd225002, 5'h12, 1'b0, 5'd2, 3'd2};
      5'd8:    p = '{20'd250003, 5'h14, 1'b0, 5'd2, 3'd2};
      5'd9:    p = '{20'd275002, 5'h16, 1'b0, 5'd2, 3'd2};
      5'd10:   p = '{20'd300002, 5'h18, 1'b0, 5'd2, 3'd2};
      5'd11:   p = '{20'd325002, 5'h1A, 1'b0, 5'd2, 3'd2};
      5'd12:   p = '{20'd350002, 5'h1C, 1'b0, 5'd2, 3'd2};
      5'd13:   p = '{20'd375003, 5'h1E, 1'b0, 5'd2, 3'd3};
      default: p = '{20'd387003, 5'h1F, 1'b0, 5'd2, 3'd3};
    endcase
    return p;
  endfunction

endpackage

// ===== design/opss_if.sv =====
// ----------------------------------------------------------------------------
// opss_if
// valid/ready channels for requests and result beats
// ----------------------------------------------------------------------------
interface opss_req_if;
  logic                        valid;
  logic                        ready;
  logic [opss_pkg::KHZ_W-1:0]  target_khz;
  logic [opss_pkg::REL_W-1:0]  relation;

  modport source (output valid, output target_khz, output relation, input ready);
  modport sink (input valid, input target_khz, input relation, output ready);
endinterface

interface opss_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [opss_pkg::ACT_W-1:0]  action;
  logic [opss_pkg::VAL_W-1:0]  write_value;
  logic [opss_pkg::KHZ_W-1:0]  chosen_khz;
  logic                        last;

  modport source (output valid, output action, output write_value, output chosen_khz,
                  output last, input ready);
  modport sink (input valid, input action, input write_value, input chosen_khz,
                input last, output ready);
endinterface

// ===== design/opss_div.sv =====
// ----------------------------------------------------------------------------
// opss_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module opss_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [opss_pkg::PROD_W-1:0]  dividend,
  input  logic [opss_pkg::CPU_W-1:0]   divisor,
  output logic                         busy,
  output logic [opss_pkg::PROD_W-1:0]  quotient
);

  localparam int PW    = opss_pkg::PROD_W;
  localparam int DW    = opss_pkg::CPU_W;
  localparam int CNT_W = $clog2(PW + 1);

  logic [PW-1:0]    q_sh;
  logic [DW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic             ge;
  logic [DW-1:0]    rem_next;

  // trial subtract of the shifted remainder
  always_comb begin
    trial    = {rem, q_sh[PW-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(PW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // shift register holds dividend bits then quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      q_sh <= dividend;
      rem  <= '0;
    end else if (busy) begin
      q_sh <= {q_sh[PW-2:0], ge};
      rem  <= rem_next;
    end
  end

  assign quotient = q_sh;

endmodule

// ===== design/opss_ctrl.sv =====
// ----------------------------------------------------------------------------
// opss_ctrl
// sequencer state machine: search, adjust, divide, decide, emit writes
// ----------------------------------------------------------------------------
module opss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  opss_pkg::stat_t  stat,
  output logic             req_ready,
  output opss_pkg::cmd_t   cmd
);

  opss_pkg::state_t                  state, state_next;
  logic [opss_pkg::SLOT_W-1:0]       slot, slot_next;

  // state and slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= opss_pkg::ST_IDLE;
      slot  <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    slot_next  = slot;
    unique case (state)
      opss_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = opss_pkg::ST_SEARCH;
        end
      end
      opss_pkg::ST_SEARCH: begin
        if (stat.search_done) begin
          state_next = opss_pkg::ST_ADJUST;
        end
      end
      opss_pkg::ST_ADJUST: begin
        state_next = opss_pkg::ST_DIVIDE;
      end
      opss_pkg::ST_DIVIDE: begin
        if (!stat.div_busy) begin
          state_next = opss_pkg::ST_DECIDE;
        end
      end
      opss_pkg::ST_DECIDE: begin
        slot_next = '0;
        if (!stat.same) begin
          state_next = opss_pkg::ST_EMIT;
        end else if (stat.out_free) begin
          state_next = opss_pkg::ST_IDLE;
        end
      end
      opss_pkg::ST_EMIT: begin
        if (slot != opss_pkg::SLOT_LAST && !stat.slot_en) begin
          slot_next = slot + 1'b1;
        end else if (stat.out_free) begin
          if (slot == opss_pkg::SLOT_LAST) begin
            state_next = opss_pkg::ST_IDLE;
          end else begin
            slot_next = slot + 1'b1;
          end
        end
      end
      default: begin
        state_next = opss_pkg::ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    req_ready       = 1'b0;
    cmd             = '0;
    cmd.slot        = slot;
    unique case (state)
      opss_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      opss_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
      end
      opss_pkg::ST_ADJUST: begin
        cmd.adjust    = 1'b1;
        cmd.div_start = 1'b1;
      end
      opss_pkg::ST_DIVIDE: begin
      end
      opss_pkg::ST_DECIDE: begin
        cmd.none = 1'b1;
        cmd.emit = stat.same && stat.out_free;
      end
      opss_pkg::ST_EMIT: begin
        cmd.emit = (slot == opss_pkg::SLOT_LAST || stat.slot_en) && stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/opss_dp.sv =====
// ----------------------------------------------------------------------------
// opss_dp
// table search, policy step, current frequency and kept register writes
// ----------------------------------------------------------------------------
module opss_dp #(
  parameter int NUM_POINTS = opss_pkg::NUM_POINTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  opss_pkg::cmd_t              cmd,
  output opss_pkg::stat_t             stat,
  input  logic [opss_pkg::KHZ_W-1:0]  target_in,
  input  logic [opss_pkg::REL_W-1:0]  relation_in,
  input  logic [opss_pkg::KHZ_W-1:0]  policy_min,
  input  logic [opss_pkg::KHZ_W-1:0]  policy_max,
  opss_rsp_if.source                  rsp
);

  localparam int IW = $clog2(NUM_POINTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_POINTS - 1);
  localparam int KW = opss_pkg::KHZ_W;
  localparam int VW = opss_pkg::VAL_W;
  localparam int PW = opss_pkg::PROD_W;

  logic [KW-1:0]                  target;
  logic [opss_pkg::REL_W-1:0]     rel;
  logic [IW-1:0]                  idx;
  opss_pkg::op_point_t            pt;
  logic [VW-1:0]                  pll;
  logic [opss_pkg::CPU_W-1:0]     core;
  logic [opss_pkg::AHB_W-1:0]     bus;

  opss_pkg::op_point_t            pt_cur, pt_below, pt_pick;
  logic [IW-1:0]                  below;
  logic                           step_down;
  logic [PW-1:0]                  prod;
  logic                           div_busy;
  logic [PW-1:0]                  quot;
  logic [PW-1:0]                  cur_khz;
  logic [VW-1:0]                  want_pll;
  logic                           order_a;
  opss_pkg::action_t              act;
  logic                           slot_en;
  logic [VW-1:0]                  value;

  // request capture and linear table search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target <= target_in;
      rel    <= relation_in;
      idx    <= '0;
    end else if (cmd.search_step && !stat.search_done) begin
      idx <= idx + 1'b1;
    end
  end

  assign pt_cur   = opss_pkg::rom_point(opss_pkg::ROM_IDX_W'(idx));
  assign below    = (idx != '0) ? idx - 1'b1 : '0;
  assign pt_below = opss_pkg::rom_point(opss_pkg::ROM_IDX_W'(below));

  // policy step down
  always_comb begin
    if (rel == opss_pkg::REL_ABOVE) begin
      step_down = (pt_cur.khz > policy_max) && (idx != '0);
    end else if (rel == opss_pkg::REL_BELOW) begin
      step_down = (pt_cur.khz > target) && (pt_below.khz >= policy_min);
    end else begin
      step_down = 1'b0;
    end
    pt_pick = step_down ? pt_below : pt_cur;
  end

  always_ff @(posedge clk) begin
    if (cmd.adjust) begin
      pt <= pt_pick;
    end
  end

  // current frequency from kept pll and cpu divider
  assign prod = opss_pkg::BASE_KHZ * PW'(pll[opss_pkg::MUL_W-1:0]);

  opss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (core),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_comb begin
    if (core == '0) begin
      cur_khz = '0;
    end else if (pll[opss_pkg::BYPASS_BIT]) begin
      cur_khz = quot;
    end else begin
      cur_khz = quot >> 1;
    end
  end

  // write slot decode
  assign want_pll = {pt.bypass, (VW - opss_pkg::MUL_W - 1)'(0), pt.mul};
  assign order_a  = pt.ahb > opss_pkg::AHB_W'(1);

  always_comb begin
    if (cmd.none) begin
      act = opss_pkg::ACT_NONE;
    end else begin
      unique case (cmd.slot)
        2'd0:    act = order_a ? opss_pkg::ACT_AHB : opss_pkg::ACT_PLL;
        2'd1:    act = order_a ? opss_pkg::ACT_PLL : opss_pkg::ACT_CPU;
        2'd2:    act = order_a ? opss_pkg::ACT_CPU : opss_pkg::ACT_AHB;
        default: act = opss_pkg::ACT_RESTART;
      endcase
    end
    unique case (act)
      opss_pkg::ACT_AHB: begin
        slot_en = pt.ahb != bus;
        value   = VW'(pt.ahb);
      end
      opss_pkg::ACT_PLL: begin
        slot_en = order_a ? (want_pll != pll) : (pll != '0);
        value   = want_pll;
      end
      opss_pkg::ACT_CPU: begin
        slot_en = pt.cpu != core;
        value   = VW'(pt.cpu);
      end
      default: begin
        slot_en = 1'b1;
        value   = '0;
      end
    endcase
  end

  // kept registers follow each emitted write
  always_ff @(posedge clk) begin
    if (rst) begin
      pll  <= opss_pkg::PLL_RESET;
      core <= opss_pkg::CPU_RESET;
      bus  <= opss_pkg::AHB_RESET;
    end else if (cmd.emit) begin
      if (act == opss_pkg::ACT_AHB) begin
        bus <= pt.ahb;
      end
      if (act == opss_pkg::ACT_PLL) begin
        pll <= want_pll;
      end
      if (act == opss_pkg::ACT_CPU) begin
        core <= pt.cpu;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.action      <= act;
      rsp.write_value <= value;
      rsp.chosen_khz  <= pt.khz;
      rsp.last        <= (act == opss_pkg::ACT_RESTART) || (act == opss_pkg::ACT_NONE);
    end
  end

  // status back to the controller
  always_comb begin
    stat.search_done = (pt_cur.khz >= target) || (idx == LAST_IDX);
    stat.div_busy    = div_busy;
    stat.same        = {1'b0, pt.khz} == cur_khz;
    stat.slot_en     = slot_en;
    stat.out_free    = !rsp.valid || rsp.ready;
  end

endmodule

// ===== design/operating_point_select_sequencer.sv =====
// ----------------------------------------------------------------------------
// operating_point_select_sequencer
// picks an operating point for a target frequency and sequences the writes
// ----------------------------------------------------------------------------
// sequence: linear table search, adjust, serial divide of the current
//   frequency, decide, then up to four result beats
// requests: one at a time; a new request is accepted only back in idle, after the
//   last result beat has been handed to the output register
// reset: synchronous rst restores policy and kept pll/divider values, no sweep
module operating_point_select_sequencer #(
  parameter int NUM_POINTS = opss_pkg::NUM_POINTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [opss_pkg::ADDR_W-1:0]   paddr,
  input  logic [opss_pkg::DATA_W-1:0]   pwdata,
  output logic [opss_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  opss_req_if.sink                      req,
  opss_rsp_if.source                    rsp
);

  `include "operating_point_select_sequencer_macros.svh"

  localparam int KW    = opss_pkg::KHZ_W;
  localparam int RIDX_W = opss_pkg::ADDR_W - 2;

  logic [KW-1:0]       policy_min;
  logic [KW-1:0]       policy_max;
  logic [RIDX_W-1:0]   reg_idx;
  logic                cfg_wr;
  opss_pkg::cmd_t      cmd;
  opss_pkg::stat_t     stat;
  logic                req_ready;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[opss_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_min <= opss_pkg::POLICY_MIN_RESET;
      policy_max <= opss_pkg::POLICY_MAX_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == RIDX_W'(opss_pkg::REG_POLICY_MIN)) begin
        policy_min <= pwdata[KW-1:0];
      end
      if (reg_idx == RIDX_W'(opss_pkg::REG_POLICY_MAX)) begin
        policy_max <= pwdata[KW-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    if (reg_idx == RIDX_W'(opss_pkg::REG_POLICY_MAX)) begin
      prdata = opss_pkg::DATA_W'(policy_max);
    end else begin
      prdata = opss_pkg::DATA_W'(policy_min);
    end
  end

  assign req.ready = req_ready;

  opss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  opss_dp #(
    .NUM_POINTS (NUM_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .target_in   (req.target_khz),
    .relation_in (req.relation),
    .policy_min  (policy_min),
    .policy_max  (policy_max),
    .rsp         (rsp)
  );

  // checks
  `OPSS_ASSERT_IMP(a_emit_into_free, cmd.emit, !rsp.valid || rsp.ready)
  `OPSS_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  `OPSS_ASSERT_IMP(a_last_on_final, rsp.valid, rsp.last == (rsp.action >= opss_pkg::ACT_RESTART))
  `OPSS_ASSERT_IMP(a_div_start_idle, cmd.div_start, !stat.div_busy)

endmodule

// ===== verif/opss_write_sequence_checker.sv =====
// ----------------------------------------------------------------------------
// opss_write_sequence_checker
// watches the request, result and register channels of the operating point
// sequencer, works out the register write beats each request should produce
// and compares every result beat against the oldest one still outstanding
// ----------------------------------------------------------------------------
module opss_write_sequence_checker #(
  parameter int NUM_POINTS = opss_pkg::NUM_POINTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [opss_pkg::ADDR_W-1:0] paddr,
  input  logic [opss_pkg::DATA_W-1:0] pwdata,
  opss_req_if                         req,
  opss_rsp_if                         rsp,
  output int                          failures,
  output int                          pending,
  output int                          beats
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KHZ_W      = opss_pkg::KHZ_W;
  localparam int REL_W      = opss_pkg::REL_W;
  localparam int VAL_W      = opss_pkg::VAL_W;
  localparam int MUL_W      = opss_pkg::MUL_W;
  localparam int CPU_W      = opss_pkg::CPU_W;
  localparam int AHB_W      = opss_pkg::AHB_W;
  localparam int ADDR_W     = opss_pkg::ADDR_W;
  localparam int BYPASS_BIT = opss_pkg::BYPASS_BIT;

  localparam int unsigned CORE_BASE_KHZ = 66000;
  localparam logic [CPU_W-1:0] POINT_CPU_DIV = 5'd2;
  localparam int SHOWN_LIMIT = 25;

  typedef struct {
    opss_pkg::action_t action;
    logic [VAL_W-1:0]  value;
    logic [KHZ_W-1:0]  khz;
    logic              last;
  } write_beat_t;

  typedef struct packed {
    logic [KHZ_W-1:0] khz;
    logic [MUL_W-1:0] mul;
    logic [AHB_W-1:0] ahb;
  } point_t;

  write_beat_t      planned_beats[$];
  logic [KHZ_W-1:0] floor_khz;
  logic [KHZ_W-1:0] ceiling_khz;
  logic [VAL_W-1:0] pll_kept;
  logic [CPU_W-1:0] cpu_div_kept;
  logic [AHB_W-1:0] ahb_div_kept;
  int               fault_total;
  int               beat_total;

  // operating point table, indexes past the end repeat the top entry
  function automatic point_t op_point(int idx);
    point_t p;
    int     k;
    k = (idx >= NUM_POINTS) ? NUM_POINTS - 1 : idx;
    case (k)
      0:       p = '{20'd50001,  5'h04, 3'd1};
      1:       p = '{20'd75001,  5'h06, 3'd1};
      2:       p = '{20'd100001, 5'h08, 3'd1};
      3:       p = '{20'd125002, 5'h0A, 3'd2};
      4:       p = '{20'd150002, 5'h0C, 3'd2};
      5:       p = '{20'd175002, 5'h0E, 3'd2};
      6:       p = '{20'd200002, 5'h10, 3'd2};
      7:       p = '{20'd225002, 5'h12, 3'd2};
      8:       p = '{20'd250003, 5'h14, 3'd2};
      9:       p = '{20'd275002, 5'h16, 3'd2};
      10:      p = '{20'd300002, 5'h18, 3'd2};
      11:      p = '{20'd325002, 5'h1A, 3'd2};
      12:      p = '{20'd350002, 5'h1C, 3'd2};
      13:      p = '{20'd375003, 5'h1E, 3'd3};
      default: p = '{20'd387003, 5'h1F, 3'd3};
    endcase
    return p;
  endfunction

  // frequency the kept pll and divider registers give
  function automatic logic [KHZ_W-1:0] running_khz();
    int unsigned f;
    if (cpu_div_kept == '0) return '0;
    f = (CORE_BASE_KHZ * 32'(pll_kept[MUL_W-1:0])) / 32'(cpu_div_kept);
    if (!pll_kept[BYPASS_BIT]) f = f / 2;
    return f[KHZ_W-1:0];
  endfunction

  function automatic void queue_beat(opss_pkg::action_t a, logic [VAL_W-1:0] v,
                                     logic [KHZ_W-1:0] khz, logic l);
    write_beat_t b;
    b = '{a, v, khz, l};
    planned_beats.push_back(b);
  endfunction

  // pick the operating point and queue the write beats it needs
  task automatic plan_sequence(input logic [KHZ_W-1:0] target,
                               input logic [REL_W-1:0] rel);
    int               idx;
    int               below;
    point_t           here;
    point_t           lower;
    logic [KHZ_W-1:0] chosen;
    logic [VAL_W-1:0] want_pll;
    idx = NUM_POINTS - 1;
    for (int i = NUM_POINTS - 1; i >= 0; i--) begin
      here = op_point(i);
      if (here.khz >= target) idx = i;
    end
    here = op_point(idx);
    // step down from the first point is clamped at the first point
    if (rel == opss_pkg::REL_ABOVE) begin
      if (here.khz > ceiling_khz && idx > 0) idx--;
    end else if (rel == opss_pkg::REL_BELOW) begin
      below = (idx > 0) ? idx - 1 : 0;
      lower = op_point(below);
      if (here.khz > target && lower.khz >= floor_khz) idx = below;
    end
    here = op_point(idx);
    chosen = here.khz;
    if (chosen == running_khz()) begin
      queue_beat(opss_pkg::ACT_NONE, '0, chosen, 1'b1);
      return;
    end
    want_pll = {{(VAL_W-MUL_W){1'b0}}, here.mul};
    if (here.ahb > 3'd1) begin
      // raising the bus divider first
      if (here.ahb != ahb_div_kept) begin
        ahb_div_kept = here.ahb;
        queue_beat(opss_pkg::ACT_AHB, VAL_W'(here.ahb), chosen, 1'b0);
      end
      if (want_pll != pll_kept) begin
        pll_kept = want_pll;
        queue_beat(opss_pkg::ACT_PLL, want_pll, chosen, 1'b0);
      end
      if (POINT_CPU_DIV != cpu_div_kept) begin
        cpu_div_kept = POINT_CPU_DIV;
        queue_beat(opss_pkg::ACT_CPU, VAL_W'(POINT_CPU_DIV), chosen, 1'b0);
      end
    end else begin
      // pll rewritten even when unchanged
      if (pll_kept != '0) begin
        pll_kept = want_pll;
        queue_beat(opss_pkg::ACT_PLL, want_pll, chosen, 1'b0);
      end
      if (POINT_CPU_DIV != cpu_div_kept) begin
        cpu_div_kept = POINT_CPU_DIV;
        queue_beat(opss_pkg::ACT_CPU, VAL_W'(POINT_CPU_DIV), chosen, 1'b0);
      end
      if (here.ahb != ahb_div_kept) begin
        ahb_div_kept = here.ahb;
        queue_beat(opss_pkg::ACT_AHB, VAL_W'(here.ahb), chosen, 1'b0);
      end
    end
    queue_beat(opss_pkg::ACT_RESTART, '0, chosen, 1'b1);
  endtask

  task automatic flag_field(input string field, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    fault_total++;
    if (fault_total <= SHOWN_LIMIT)
      $display("%0t: result %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  // one pass per edge: register writes, request beats, then result beats
  always @(posedge clk) begin
    write_beat_t want;
    int          reg_sel;
    if (rst) begin
      planned_beats.delete();
      floor_khz    = opss_pkg::POLICY_MIN_RESET;
      ceiling_khz  = opss_pkg::POLICY_MAX_RESET;
      pll_kept     = opss_pkg::PLL_RESET;
      cpu_div_kept = opss_pkg::CPU_RESET;
      ahb_div_kept = opss_pkg::AHB_RESET;
      fault_total  = 0;
      beat_total   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_sel = int'(paddr[ADDR_W-1:2]);
        if (reg_sel == opss_pkg::REG_POLICY_MIN) floor_khz = pwdata[KHZ_W-1:0];
        else if (reg_sel == opss_pkg::REG_POLICY_MAX) ceiling_khz = pwdata[KHZ_W-1:0];
      end
      if (req.valid && req.ready) plan_sequence(req.target_khz, req.relation);
      if (rsp.valid && rsp.ready) begin
        beat_total++;
        if (planned_beats.size() == 0) begin
          fault_total++;
          if (fault_total <= SHOWN_LIMIT)
            $display("%0t: result beat with none expected, got action %0d value %0d khz %0d",
                     $time, rsp.action, rsp.write_value, rsp.chosen_khz);
        end else begin
          want = planned_beats.pop_front();
          if (rsp.action !== want.action)
            flag_field("action", 32'(want.action), 32'(rsp.action));
          if (rsp.write_value !== want.value)
            flag_field("write_value", 32'(want.value), 32'(rsp.write_value));
          if (rsp.chosen_khz !== want.khz)
            flag_field("chosen_khz", 32'(want.khz), 32'(rsp.chosen_khz));
          if (rsp.last !== want.last)
            flag_field("last", 32'(want.last), 32'(rsp.last));
        end
      end
    end
    failures <= fault_total;
    pending  <= planned_beats.size();
    beats    <= beat_total;
  end

endmodule

// ===== verif/operating_point_select_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// operating_point_select_sequencer_test
// drives frequency requests in random bursts under several policy limits,
// stalls the result side on its own pattern including one long hold-off,
// and reports the verdict from the write sequence checker
// ----------------------------------------------------------------------------
module operating_point_select_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POINTS        = opss_pkg::NUM_POINTS_DEFAULT;
  localparam int PER_PHASE     = 90;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int SEED_COUNT    = 24;

  // relations with no adjustment
  localparam logic [opss_pkg::REL_W-1:0] REL_EXACT  = 2'd2;
  localparam logic [opss_pkg::REL_W-1:0] REL_SPARE  = 2'd3;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [opss_pkg::ADDR_W-1:0]   paddr;
  logic [opss_pkg::DATA_W-1:0]   pwdata;
  logic [opss_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  int                            failures;
  int                            pending;
  int                            beats;
  int                            sent;
  int                            burst_left;
  int                            settings_used;
  bit                            hold_off_request;

  opss_req_if req_ch ();
  opss_rsp_if rsp_ch ();

  operating_point_select_sequencer #(.NUM_POINTS(POINTS)) dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req(req_ch), .rsp(rsp_ch)
  );

  opss_write_sequence_checker #(.NUM_POINTS(POINTS)) write_watch (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .req(req_ch), .rsp(rsp_ch), .failures, .pending, .beats
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one request beat, opening a new burst after a random gap when needed
  task automatic offer_request(input logic [opss_pkg::KHZ_W-1:0] t,
                               input logic [opss_pkg::REL_W-1:0] r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.target_khz <= t;
    req_ch.relation   <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // targets lean on table points and their neighbors
  task automatic offer_random_request();
    opss_pkg::op_point_t          p;
    logic [opss_pkg::KHZ_W-1:0]   t;
    int                           sel;
    sel = $urandom_range(9);
    p = opss_pkg::rom_point(5'($urandom_range(POINTS - 1)));
    case (sel)
      0, 1, 2: t = p.khz;
      3:       t = p.khz + 1'b1;
      4:       t = p.khz - 1'b1;
      5:       t = ($urandom_range(1) == 1) ? '1 : '0;
      6, 7:    t = 20'($urandom_range(40000, 400000));
      default: t = 20'($urandom);
    endcase
    offer_request(t, 2'($urandom_range(3)));
  endtask

  // register write, setup then access, junk in the unused upper bits
  task automatic write_register(input int reg_index, input logic [opss_pkg::KHZ_W-1:0] khz);
    logic [opss_pkg::DATA_W-opss_pkg::KHZ_W-1:0] junk;
    junk = (opss_pkg::DATA_W - opss_pkg::KHZ_W)'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= opss_pkg::ADDR_W'(reg_index * 4);
    pwdata  <= {junk, khz};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_policy(input logic [opss_pkg::KHZ_W-1:0] lo,
                              input logic [opss_pkg::KHZ_W-1:0] hi);
    write_register(opss_pkg::REG_POLICY_MIN, lo);
    write_register(opss_pkg::REG_POLICY_MAX, hi);
    settings_used++;
  endtask

  // let every outstanding beat arrive and the block go quiet
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase();
    repeat (PER_PHASE) offer_random_request();
  endtask

  // result side stall pattern, with a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(1) == 1);
          2:       rsp_ch.ready <= ($urandom_range(3) == 0);
          default: rsp_ch.ready <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: %0d cycles without a beat, %0d beats outstanding",
             STALL_LIMIT, pending);
    $display("operating_point_select_sequencer_test: errors");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [opss_pkg::KHZ_W-1:0] seed_targets [SEED_COUNT];
    logic [opss_pkg::REL_W-1:0] seed_rels [SEED_COUNT];
    logic [opss_pkg::KHZ_W-1:0] lo;
    logic [opss_pkg::KHZ_W-1:0] hi;
    sent = 0;
    burst_left = 0;
    settings_used = 1;
    hold_off_request = 1'b0;
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.target_khz <= '0;
    req_ch.relation   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // field extremes, table boundaries, every relation, repeated points
    seed_targets = '{20'd0, 20'd0, 20'd0, 20'd0,
                     20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                     20'd50001, 20'd50002, 20'd100001, 20'd100002,
                     20'd125002, 20'd125002, 20'd125002, 20'd50001,
                     20'd50001, 20'd350002, 20'd350003, 20'd375003,
                     20'd387003, 20'd387004, 20'd225002, 20'd75001};
    seed_rels = '{opss_pkg::REL_ABOVE, opss_pkg::REL_BELOW, REL_EXACT, REL_SPARE,
                  opss_pkg::REL_ABOVE, opss_pkg::REL_BELOW, REL_EXACT, REL_SPARE,
                  opss_pkg::REL_BELOW, opss_pkg::REL_BELOW, opss_pkg::REL_BELOW,
                  opss_pkg::REL_BELOW,
                  opss_pkg::REL_ABOVE, REL_EXACT, REL_EXACT, REL_EXACT,
                  REL_EXACT, opss_pkg::REL_ABOVE, opss_pkg::REL_ABOVE, opss_pkg::REL_BELOW,
                  REL_EXACT, opss_pkg::REL_BELOW, opss_pkg::REL_BELOW, opss_pkg::REL_ABOVE};
    for (int i = 0; i < SEED_COUNT; i++) offer_request(seed_targets[i], seed_rels[i]);
    run_random_phase();
    drain_results();

    // widest window
    apply_policy(20'd0, 20'hFFFFF);
    run_random_phase();
    drain_results();

    // inverted extremes, with the long result hold-off
    apply_policy(20'hFFFFF, 20'd0);
    repeat (5) offer_random_request();
    hold_off_request = 1'b1;
    run_random_phase();
    drain_results();

    // arbitrary limits
    lo = 20'($urandom);
    hi = 20'($urandom);
    apply_policy(lo, hi);
    run_random_phase();
    drain_results();

    // limits sitting on table points, then back to the boot policy
    apply_policy(20'd150002, 20'd250003);
    run_random_phase();
    drain_results();
    apply_policy(opss_pkg::POLICY_MIN_RESET, opss_pkg::POLICY_MAX_RESET);
    repeat (PER_PHASE / 3) offer_random_request();
    drain_results();

    $display("covered %0d requests and %0d result beats across %0d policy settings",
             sent, beats, settings_used);
    if (failures == 0 && pending == 0)
      $display("operating_point_select_sequencer_test: clean");
    else
      $display("operating_point_select_sequencer_test: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/opss_pkg.sv
design/opss_if.sv
design/opss_div.sv
design/opss_ctrl.sv
design/opss_dp.sv
design/operating_point_select_sequencer.sv
verif/opss_write_sequence_checker.sv
verif/operating_point_select_sequencer_test.sv
